// File: hdl/prb_pkg.sv
// prb_pkg: command and status codes, broadcast and chain types
// shared by the reorder buffer cell, the cell row and the top level
package prb_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_GET    = 2'd1;
   localparam logic [1:0] CMD_SKIP   = 2'd2;
   localparam logic [1:0] CMD_FLUSH  = 2'd3;

   localparam logic [2:0] STS_NOW    = 3'd0;
   localparam logic [2:0] STS_BEHIND = 3'd1;
   localparam logic [2:0] STS_STORED = 3'd2;
   localparam logic [2:0] STS_FULL   = 3'd3;
   localparam logic [2:0] STS_DUP    = 3'd4;
   localparam logic [2:0] STS_OTHER  = 3'd5;

   localparam int SEQ_BITS = 32;

   // broadcast to every cell
   typedef struct packed {
      logic store;
      logic take;
      logic release_one;
      logic flush_mode;
   } cmd_type;

   // passed from each cell to the next one up
   typedef struct packed {
      logic free_seen;
      logic mark_seen;
      logic match_seen;
      logic stale_seen;
      logic more_marks;
   } chain_type;

endpackage

// File: hdl/prb_cell.sv
// prb_cell: one table slot of the reorder buffer with its compare logic
// depends on prb_pkg
module prb_cell import prb_pkg::*; #(
   parameter int HANDLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic [SEQ_BITS-1:0]    key,
   input  logic [SEQ_BITS-1:0]    expected,
   input  logic [SEQ_BITS-1:0]    seq_in,
   input  logic [HANDLE_BITS-1:0] handle_in,
   input  chain_type              chain_in,
   input  logic [HANDLE_BITS-1:0] take_h_in,
   input  logic [HANDLE_BITS-1:0] rel_h_in,
   output chain_type              chain_out,
   output logic [HANDLE_BITS-1:0] take_h_out,
   output logic [HANDLE_BITS-1:0] rel_h_out
);

   logic                   valid_ff, valid_in;
   logic [SEQ_BITS-1:0]    seq_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [SEQ_BITS-1:0]    diff;
   logic                   match, behind, free, mark, claim, pick;

   assign diff   = seq_ff - expected;
   assign match  = valid_ff && (seq_ff == key);
   assign behind = valid_ff && diff[SEQ_BITS-1];
   assign free   = !valid_ff;
   assign mark   = valid_ff && (cmd.flush_mode || diff[SEQ_BITS-1]);
   assign claim  = free && !chain_in.free_seen;
   assign pick   = mark && !chain_in.mark_seen;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.store && claim) begin
         valid_in = 1'b1;
      end
      if (cmd.take && match) begin
         valid_in = 1'b0;
      end
      if (cmd.release_one && pick) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store && claim) begin
         seq_ff    <= seq_in;
         handle_ff <= handle_in;
      end
   end

   assign chain_out.free_seen  = chain_in.free_seen | free;
   assign chain_out.mark_seen  = chain_in.mark_seen | mark;
   assign chain_out.match_seen = chain_in.match_seen | match;
   assign chain_out.stale_seen = chain_in.stale_seen | behind;
   assign chain_out.more_marks = chain_in.more_marks | (mark & chain_in.mark_seen);

   assign take_h_out = match ? handle_ff : take_h_in;
   assign rel_h_out  = pick ? handle_ff : rel_h_in;

endmodule

// File: hdl/prb_row.sv
// prb_row: the row of slot cells, chained from slot 0 upward
// depends on prb_pkg and prb_cell
module prb_row import prb_pkg::*; #(
   parameter int SLOTS = 16,
   parameter int HANDLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic [SEQ_BITS-1:0]    key,
   input  logic [SEQ_BITS-1:0]    expected,
   input  logic [SEQ_BITS-1:0]    seq_in,
   input  logic [HANDLE_BITS-1:0] handle_in,
   output chain_type              chain_end,
   output logic [HANDLE_BITS-1:0] take_handle,
   output logic [HANDLE_BITS-1:0] rel_handle
);

   chain_type              chain [SLOTS+1];
   logic [HANDLE_BITS-1:0] take_h [SLOTS+1];
   logic [HANDLE_BITS-1:0] rel_h [SLOTS+1];

   assign chain[0]  = '0;
   assign take_h[0] = '0;
   assign rel_h[0]  = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      prb_cell #(
         .HANDLE_BITS(HANDLE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .key        (key),
         .expected   (expected),
         .seq_in     (seq_in),
         .handle_in  (handle_in),
         .chain_in   (chain[i]),
         .take_h_in  (take_h[i]),
         .rel_h_in   (rel_h[i]),
         .chain_out  (chain[i+1]),
         .take_h_out (take_h[i+1]),
         .rel_h_out  (rel_h[i+1])
      );
   end

   assign chain_end   = chain[SLOTS];
   assign take_handle = take_h[SLOTS];
   assign rel_handle  = rel_h[SLOTS];

endmodule

// File: hdl/packet_reorder_buffer_top.sv
// packet_reorder_buffer_top: command sequencer, expected sequence state and results
// depends on prb_pkg and prb_row
//
// usage
// - commands enter on req_*: a word is taken at a clock edge with start high and busy low
// - csr_* writes seq_step (always ready); write only while the block is idle
// - results leave on rsp_*, one word per cycle marked by rsp_valid; rsp_last ends a command
// - insert and get: one result word, registered from the execute state, then back to idle
// - skip: step product registered at accept, the add state moves the expected number, then one word per
//   released slot (at least one), after which the block returns to idle
// - flush: one word per released slot (at least one), registered from the release state
// - lowest free slot and release order come from a priority chain through the cell row
// - synchronous reset clears every slot, expected number to 0, first flag set, step to 1
// - the receiver cannot stall: each result word is shown for exactly one cycle
module packet_reorder_buffer_top import prb_pkg::*; #(
   parameter int SLOTS = 16,
   parameter int HANDLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_seq,
   input  logic [15:0] req_handle,
   input  logic [15:0] req_skip_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_out_handle,
   output logic        rsp_handle_valid,
   output logic        rsp_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_ADD  = 2'd2;
   localparam logic [1:0] ST_REL  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [15:0]            step_ff;
   logic [SEQ_BITS-1:0]    expected_ff, expected_in;
   logic                   first_ff, first_in;
   logic [1:0]             cmd_ff;
   logic [SEQ_BITS-1:0]    seq_ff;
   logic [HANDLE_BITS-1:0] hnd_ff;
   logic [SEQ_BITS-1:0]    product_ff;
   logic                   accept;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;
   logic [15:0]            rsp_handle_ff, rsp_handle_in;
   logic                   rsp_hv_ff, rsp_hv_in;
   logic                   rsp_last_ff, rsp_last_in;

   cmd_type                cmd;
   chain_type              chain_end;
   logic [SEQ_BITS-1:0]    key, seq_diff;
   logic [HANDLE_BITS-1:0] take_handle, rel_handle, req_h_trim;
   logic [HANDLE_BITS+15:0] req_h_wide;
   logic [HANDLE_BITS+15:0] hnd_wide, take_wide, rel_wide;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign req_h_wide = {{HANDLE_BITS{1'b0}}, req_handle};
   assign req_h_trim = req_h_wide[HANDLE_BITS-1:0];
   assign hnd_wide   = {16'd0, hnd_ff};
   assign take_wide  = {16'd0, take_handle};
   assign rel_wide   = {16'd0, rel_handle};

   assign key      = (cmd_ff == CMD_GET) ? expected_ff : seq_ff;
   assign seq_diff = seq_ff - expected_ff;

   prb_row #(
      .SLOTS       (SLOTS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_row (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .key         (key),
      .expected    (expected_ff),
      .seq_in      (seq_ff),
      .handle_in   (hnd_ff),
      .chain_end   (chain_end),
      .take_handle (take_handle),
      .rel_handle  (rel_handle)
   );

   always_comb begin
      state_in       = state_ff;
      expected_in    = expected_ff;
      first_in       = first_ff;
      cmd            = '0;
      cmd.flush_mode = (cmd_ff == CMD_FLUSH);
      rsp_valid_in   = 1'b0;
      rsp_status_in  = STS_OTHER;
      rsp_handle_in  = 16'd0;
      rsp_hv_in      = 1'b0;
      rsp_last_in    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_SKIP: begin
                     state_in = ST_ADD;
                  end
                  CMD_FLUSH: begin
                     state_in    = ST_REL;
                     expected_in = '0;
                     first_in    = 1'b1;
                  end
                  default: begin
                     state_in = ST_EXEC;
                  end
               endcase
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (cmd_ff == CMD_GET) begin
               if (chain_end.match_seen && !chain_end.stale_seen) begin
                  cmd.take      = 1'b1;
                  rsp_hv_in     = 1'b1;
                  rsp_handle_in = take_wide[15:0];
               end
            end else if ((seq_ff == expected_ff) || first_ff) begin
               expected_in   = seq_ff + {16'd0, step_ff};
               first_in      = 1'b0;
               rsp_status_in = STS_NOW;
               rsp_hv_in     = 1'b1;
               rsp_handle_in = hnd_wide[15:0];
            end else if (seq_diff[SEQ_BITS-1]) begin
               rsp_status_in = STS_BEHIND;
               rsp_hv_in     = 1'b1;
               rsp_handle_in = hnd_wide[15:0];
            end else if (chain_end.match_seen) begin
               rsp_status_in = STS_DUP;
               rsp_hv_in     = 1'b1;
               rsp_handle_in = hnd_wide[15:0];
            end else if (!chain_end.free_seen) begin
               rsp_status_in = STS_FULL;
               rsp_hv_in     = 1'b1;
               rsp_handle_in = hnd_wide[15:0];
            end else begin
               cmd.store     = 1'b1;
               rsp_status_in = STS_STORED;
            end
         end
         ST_ADD: begin
            state_in    = ST_REL;
            expected_in = expected_ff + product_ff;
         end
         ST_REL: begin
            rsp_valid_in = 1'b1;
            if (chain_end.mark_seen) begin
               cmd.release_one = 1'b1;
               rsp_hv_in       = 1'b1;
               rsp_handle_in   = rel_wide[15:0];
               rsp_last_in     = !chain_end.more_marks;
            end
            if (rsp_last_in) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 16'd1;
         expected_ff  <= '0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         expected_ff  <= expected_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            step_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_command;
         seq_ff     <= req_seq;
         hnd_ff     <= req_h_trim;
         product_ff <= {16'd0, req_skip_count} * {16'd0, step_ff};
      end
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_hv_ff     <= rsp_hv_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_handle   = rsp_handle_ff;
   assign rsp_handle_valid = rsp_hv_ff;
   assign rsp_last         = rsp_last_ff;

   a_word_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (rsp_valid && rsp_last))
      else $error("insert or get gave no single result word");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("command accepted without going busy");

   a_empty_handle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_handle_valid) |-> (rsp_out_handle == 16'd0))
      else $error("handle shown without handle_valid");

   a_one_slot_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.store, cmd.take, cmd.release_one}))
      else $error("more than one slot action at once");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REL && rsp_last_in) |=> !busy)
      else $error("still busy after final release word");

endmodule

// File: verif/tb_packet_reorder_buffer_top.sv
// tb_packet_reorder_buffer_top: self-checking testbench for the packet reorder buffer
// directed and random command streams checked against an in-bench prediction of the table
// depends on prb_pkg and packet_reorder_buffer_top
module tb_packet_reorder_buffer_top;
   timeunit 1ns;
   timeprecision 1ps;
   import prb_pkg::*;

   localparam int SLOT_COUNT = 16;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] handle;
      logic        hvalid;
      logic        last;
   } result_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_command = CMD_GET;
   logic [31:0] req_seq = '0;
   logic [15:0] req_handle = '0;
   logic [15:0] req_skip_count = '0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_out_handle;
   logic        rsp_handle_valid;
   logic        rsp_last;

   // predicted state of the buffer
   logic [15:0] seq_step;
   logic [31:0] next_seq;
   logic        first_open;
   logic        slot_used [SLOT_COUNT];
   logic [31:0] slot_sn [SLOT_COUNT];
   logic [15:0] slot_hd [SLOT_COUNT];

   result_word_type due_words[$];
   int fail_count = 0;
   int idle_pct = 0;

   packet_reorder_buffer_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_seq          (req_seq),
      .req_handle       (req_handle),
      .req_skip_count   (req_skip_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_handle   (rsp_out_handle),
      .rsp_handle_valid (rsp_handle_valid),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   function automatic logic seq_behind(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return diff[31];
   endfunction

   task automatic clear_model();
      seq_step = 16'd1;
      next_seq = '0;
      first_open = 1'b1;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_used[i] = 1'b0;
         slot_sn[i] = '0;
         slot_hd[i] = '0;
      end
   endtask

   task automatic push_word(input logic [2:0] status, input logic [15:0] hd,
                            input logic hvalid, input logic last);
      result_word_type w;
      w.status = status;
      w.handle = hvalid ? hd : 16'd0;
      w.hvalid = hvalid;
      w.last = last;
      due_words.push_back(w);
   endtask

   task automatic predict_reorder(input logic [1:0] cmd, input logic [31:0] sn,
                                  input logic [15:0] hd, input logic [15:0] cnt);
      int  free_idx;
      int  hit_idx;
      int  total;
      int  done;
      bit  dup;
      bit  stale;
      bit  marked [SLOT_COUNT];
      case (cmd)
         CMD_INSERT: begin
            if (sn == next_seq || first_open) begin
               next_seq = sn + 32'(seq_step);
               first_open = 1'b0;
               push_word(STS_NOW, hd, 1'b1, 1'b1);
            end else if (seq_behind(sn, next_seq)) begin
               push_word(STS_BEHIND, hd, 1'b1, 1'b1);
            end else begin
               free_idx = -1;
               dup = 1'b0;
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (slot_used[i] && slot_sn[i] == sn) dup = 1'b1;
                  else if (!slot_used[i] && free_idx < 0) free_idx = i;
               end
               if (dup) begin
                  push_word(STS_DUP, hd, 1'b1, 1'b1);
               end else if (free_idx < 0) begin
                  push_word(STS_FULL, hd, 1'b1, 1'b1);
               end else begin
                  slot_used[free_idx] = 1'b1;
                  slot_sn[free_idx] = sn;
                  slot_hd[free_idx] = hd;
                  push_word(STS_STORED, 16'd0, 1'b0, 1'b1);
               end
            end
         end
         CMD_GET: begin
            hit_idx = -1;
            stale = 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (slot_used[i]) begin
                  if (slot_sn[i] == next_seq) hit_idx = i;
                  else if (seq_behind(slot_sn[i], next_seq)) stale = 1'b1;
               end
            end
            if (hit_idx >= 0 && !stale) begin
               slot_used[hit_idx] = 1'b0;
               push_word(STS_OTHER, slot_hd[hit_idx], 1'b1, 1'b1);
            end else begin
               push_word(STS_OTHER, 16'd0, 1'b0, 1'b1);
            end
         end
         default: begin
            if (cmd == CMD_SKIP) begin
               next_seq = next_seq + 32'(cnt) * 32'(seq_step);
            end else begin
               next_seq = '0;
               first_open = 1'b1;
            end
            total = 0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               marked[i] = slot_used[i] &&
                           (cmd == CMD_FLUSH || seq_behind(slot_sn[i], next_seq));
               if (marked[i]) total++;
            end
            if (total == 0) begin
               push_word(STS_OTHER, 16'd0, 1'b0, 1'b1);
            end else begin
               done = 0;
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (marked[i]) begin
                     slot_used[i] = 1'b0;
                     done++;
                     push_word(STS_OTHER, slot_hd[i], 1'b1, done == total);
                  end
               end
            end
         end
      endcase
   endtask

   // start stays high from one word to the next unless an idle gap is drawn
   task automatic send_command(input logic [1:0] cmd, input logic [31:0] sn,
                               input logic [15:0] hd, input logic [15:0] cnt);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_seq <= sn;
      req_handle <= hd;
      req_skip_count <= cnt;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_reorder(cmd, sn, hd, cnt);
   endtask

   task automatic settle_block();
      start <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_step(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      seq_step = value;
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_commands();
      send_command(CMD_FLUSH, $urandom, $urandom, $urandom);
      send_command(CMD_GET, $urandom, $urandom, $urandom);
      send_command(CMD_SKIP, $urandom, $urandom, 16'hFFFF);
   endtask

   task automatic test_first_and_wrap();
      send_command(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
      send_command(CMD_INSERT, 32'h8000_0000, 16'h0000, 16'hFFFF);
      send_command(CMD_INSERT, 32'h7FFF_FFFF, 16'h1234, 16'h0000);
      send_command(CMD_INSERT, 32'h7FFF_FFFF, 16'hABCD, 16'h0000);
      send_command(CMD_INSERT, 32'd2, 16'h5A5A, 16'h0000);
      send_command(CMD_GET, 32'd0, 16'h0000, 16'h0000);
      send_command(CMD_INSERT, 32'd0, 16'hA5A5, 16'h0000);
      send_command(CMD_SKIP, 32'd0, 16'h0000, 16'd1);
      send_command(CMD_GET, 32'd0, 16'h0000, 16'h0000);
      send_command(CMD_FLUSH, 32'd0, 16'h0000, 16'h0000);
   endtask

   // a slot left behind by an in-order packet blocks get until a skip clears it
   task automatic test_stale_get();
      settle_block();
      write_step(16'd5);
      send_command(CMD_INSERT, 32'd100, 16'h0100, 16'd0);
      send_command(CMD_INSERT, 32'd108, 16'h0108, 16'd0);
      send_command(CMD_INSERT, 32'd110, 16'h0110, 16'd0);
      send_command(CMD_INSERT, 32'd105, 16'h0105, 16'd0);
      send_command(CMD_GET, 32'd0, 16'd0, 16'd0);
      send_command(CMD_SKIP, 32'd0, 16'd0, 16'd0);
      send_command(CMD_GET, 32'd0, 16'd0, 16'd0);
   endtask

   task automatic test_table_full();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         send_command(CMD_INSERT, 32'd200 + 32'(i) * 32'd5, 16'(16'hC000 + i), 16'd0);
      end
      send_command(CMD_INSERT, 32'd1000, 16'hDEAD, 16'd0);
      send_command(CMD_FLUSH, 32'd0, 16'd0, 16'd0);
   endtask

   task automatic test_random_stream(input logic [15:0] step, input int pct, input int count);
      int unsigned pick;
      int unsigned base;
      logic [1:0]  cmd;
      logic [31:0] sn;
      logic [15:0] cnt;
      settle_block();
      write_step(step);
      idle_pct = pct;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         sn = $urandom;
         cnt = $urandom;
         cmd = CMD_INSERT;
         if (pick < 45) begin
            base = $urandom_range(6);
            if (base == 6) sn = next_seq - 32'(seq_step);
            else sn = next_seq + 32'(base) * 32'(seq_step);
         end else if (pick < 65) begin
            cmd = CMD_GET;
         end else if (pick < 75) begin
            cmd = CMD_SKIP;
            cnt = $urandom_range(3);
         end else if (pick < 78) begin
            cmd = CMD_SKIP;
         end else if (pick < 82) begin
            cmd = CMD_FLUSH;
         end else if (pick < 88) begin
            base = $urandom_range(SLOT_COUNT - 1);
            for (int j = 0; j < SLOT_COUNT; j++) begin
               if (slot_used[(base + j) % SLOT_COUNT]) sn = slot_sn[(base + j) % SLOT_COUNT];
            end
         end
         send_command(cmd, sn, $urandom, cnt);
      end
   endtask

   always @(posedge clock) begin : check_words
      result_word_type w;
      if (!reset && rsp_valid === 1'b1) begin
         if (due_words.size() == 0) begin
            report_failure($sformatf("unexpected word: status %0d handle %h hv %b last %b",
                                     rsp_status, rsp_out_handle, rsp_handle_valid, rsp_last));
         end else begin
            w = due_words.pop_front();
            if (rsp_status !== w.status || rsp_out_handle !== w.handle ||
                rsp_handle_valid !== w.hvalid || rsp_last !== w.last) begin
               report_failure($sformatf(
                  "mismatch: exp status %0d handle %h hv %b last %b, got %0d %h %b %b",
                  w.status, w.handle, w.hvalid, w.last,
                  rsp_status, rsp_out_handle, rsp_handle_valid, rsp_last));
            end
         end
      end
   end

   initial begin
      #2ms;
      $display("tb_packet_reorder_buffer_top NOT OK");
      $finish;
   end

   initial begin
      clear_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_commands();
      test_first_and_wrap();
      test_stale_get();
      test_table_full();
      test_random_stream(16'd1, 0, 18);
      test_random_stream(16'hFFFF, 57, 18);
      test_random_stream(16'($urandom_range(65534, 2)), 27, 18);
      test_random_stream(16'd3, 0, 18);
      settle_block();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && due_words.size() == 0) begin
         $display("tb_packet_reorder_buffer_top OK");
      end else begin
         $display("tb_packet_reorder_buffer_top NOT OK");
      end
      $finish;
   end

endmodule
